// ----- hdl/aat_pkg.sv -----
// types, constants and helpers shared by the box transform block
`timescale 1ns / 1ps
package aat_pkg;

  localparam int NumRegs  = 6;
  localparam int CfgAddrW = 6;
  localparam int RegIdxW  = 3;
  localparam int CfgDataW = 64;

  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] prod_t;
  typedef logic signed [47:0] term_t;
  typedef logic signed [49:0] acc_t;

  localparam logic [RegIdxW-1:0] RegRow0Cols01 = 3'd0;
  localparam logic [RegIdxW-1:0] RegRow0Cols23 = 3'd1;
  localparam logic [RegIdxW-1:0] RegRow1Cols01 = 3'd2;
  localparam logic [RegIdxW-1:0] RegRow1Cols23 = 3'd3;
  localparam logic [RegIdxW-1:0] RegRow2Cols01 = 3'd4;
  localparam logic [RegIdxW-1:0] RegRow2Cols23 = 3'd5;

  localparam logic [CfgDataW-1:0] RegReset [NumRegs] = '{
    64'h0000_0001_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

  localparam acc_t SatMax = 50'sd2147483647;
  localparam acc_t SatMin = -50'sd2147483648;

  function automatic q16_t sat32(acc_t v);
    q16_t r;
    if (v > SatMax) begin
      r = 32'sh7fff_ffff;
    end else if (v < SatMin) begin
      r = 32'sh8000_0000;
    end else begin
      r = q16_t'(v[31:0]);
    end
    return r;
  endfunction

endpackage

// ----- hdl/aat_box_if.sv -----
// input channel: local box corners
`timescale 1ns / 1ps
interface aat_box_if;
  import aat_pkg::*;

  logic valid;
  logic ready;
  q16_t box_lo_x;
  q16_t box_lo_y;
  q16_t box_lo_z;
  q16_t box_hi_x;
  q16_t box_hi_y;
  q16_t box_hi_z;

  modport source (
    output valid, box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
    input  ready
  );
  modport sink (
    input  valid, box_lo_x, box_lo_y, box_lo_z, box_hi_x, box_hi_y, box_hi_z,
    output ready
  );
endinterface

// ----- hdl/aat_world_if.sv -----
// output channel: world-space box corners
`timescale 1ns / 1ps
interface aat_world_if;
  import aat_pkg::*;

  logic valid;
  logic ready;
  q16_t world_lo_x;
  q16_t world_lo_y;
  q16_t world_lo_z;
  q16_t world_hi_x;
  q16_t world_hi_y;
  q16_t world_hi_z;

  modport source (
    output valid, world_lo_x, world_lo_y, world_lo_z,
    output world_hi_x, world_hi_y, world_hi_z,
    input  ready
  );
  modport sink (
    input  valid, world_lo_x, world_lo_y, world_lo_z,
    input  world_hi_x, world_hi_y, world_hi_z,
    output ready
  );
endinterface

// ----- hdl/aabb_affine_transform.sv -----
// affine transform of an axis-aligned box, five-stage pipeline with apb registers
//
// box_i takes one local box per beat (lo and hi corners, signed Q16.16).
// world_o gives the enclosing world box under the 3x4 affine matrix held in
// six 64-bit registers on the apb port (register i at byte address 8*i).
// Stages: input register, 18 parallel 32x32 products, floor cut with per-term
// min/max, translation plus two terms, last term plus saturation into the
// output register.
// Throughput: one box per cycle unless the output stalls, set by the per-stage
// product array; every stage holds its own valid bit.
// Stall: when world_o.ready is low the output register holds; empty stages
// ahead of it keep filling, and box_i.ready drops once all five stages hold a
// beat. Nothing is lost or repeated.
// Reset: all valid bits clear and the matrix returns to its fixed reset value
// with zero translation. Registers must be written only while the pipeline
// is empty, by the user; the block does not enforce it. pready is tied high.
`timescale 1ns / 1ps
module aabb_affine_transform (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  aat_box_if.sink                       box_i,
  aat_world_if.source                   world_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aat_pkg::CfgAddrW-1:0]  paddr,
  input  logic [aat_pkg::CfgDataW-1:0]  pwdata,
  output logic [aat_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import aat_pkg::*;

  localparam int NumStages = 5;

  // configuration registers
  logic [CfgDataW-1:0] cfg_q [NumRegs];
  logic [RegIdxW-1:0]  reg_idx;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:CfgAddrW-RegIdxW];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        cfg_q[i] <= RegReset[i];
      end
    end else if (cfg_wr && (reg_idx <= RegRow2Cols23)) begin
      cfg_q[reg_idx] <= pwdata;
    end
  end

  always_comb begin
    if (reg_idx <= RegRow2Cols23) begin
      prdata = cfg_q[reg_idx];
    end else begin
      prdata = '0;
    end
  end

  // matrix entries and translation
  q16_t m [3][3];
  q16_t t [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      m[r][0] = q16_t'(cfg_q[2*r][31:0]);
      m[r][1] = q16_t'(cfg_q[2*r][63:32]);
      m[r][2] = q16_t'(cfg_q[2*r+1][31:0]);
      t[r]    = q16_t'(cfg_q[2*r+1][63:32]);
    end
  end

  // pipeline flow control
  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] rdy;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] vin;

  always_comb begin
    rdy[NumStages-1] = world_o.ready || !valid_q[NumStages-1];
    for (int k = NumStages-2; k >= 0; k--) begin
      rdy[k] = rdy[k+1] || !valid_q[k];
    end
    vin[0] = box_i.valid;
    for (int k = 1; k < NumStages; k++) begin
      vin[k] = valid_q[k-1];
    end
    en = rdy & vin;
  end

  assign box_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (rdy[k]) begin
          valid_q[k] <= vin[k];
        end
      end
    end
  end

  // stage 0: input corners
  q16_t a_q [3];
  q16_t b_q [3];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      a_q[0] <= box_i.box_lo_x;
      a_q[1] <= box_i.box_lo_y;
      a_q[2] <= box_i.box_lo_z;
      b_q[0] <= box_i.box_hi_x;
      b_q[1] <= box_i.box_hi_y;
      b_q[2] <= box_i.box_hi_z;
    end
  end

  // stage 1: exact products for both corner coordinates
  prod_t pa_q [3][3];
  prod_t pb_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          pa_q[r][c] <= m[r][c] * a_q[c];
          pb_q[r][c] <= m[r][c] * b_q[c];
        end
      end
    end
  end

  // stage 2: floor to Q32.16 and order each term pair
  term_t lo_d [3][3];
  term_t hi_d [3][3];
  term_t lo_q [3][3];
  term_t hi_q [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        term_t sa;
        term_t sb;
        sa = term_t'(pa_q[r][c][63:16]);
        sb = term_t'(pb_q[r][c][63:16]);
        if (sa < sb) begin
          lo_d[r][c] = sa;
          hi_d[r][c] = sb;
        end else begin
          lo_d[r][c] = sb;
          hi_d[r][c] = sa;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  // stage 3: translation plus the x and y terms, z term carried along
  acc_t  plo_q [3];
  acc_t  phi_q [3];
  term_t zlo_q [3];
  term_t zhi_q [3];

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        plo_q[r] <= acc_t'(t[r]) + acc_t'(lo_q[r][0]) + acc_t'(lo_q[r][1]);
        phi_q[r] <= acc_t'(t[r]) + acc_t'(hi_q[r][0]) + acc_t'(hi_q[r][1]);
        zlo_q[r] <= lo_q[r][2];
        zhi_q[r] <= hi_q[r][2];
      end
    end
  end

  // stage 4: last term, saturate into the output register
  q16_t wlo_q [3];
  q16_t whi_q [3];

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      for (int r = 0; r < 3; r++) begin
        wlo_q[r] <= sat32(plo_q[r] + acc_t'(zlo_q[r]));
        whi_q[r] <= sat32(phi_q[r] + acc_t'(zhi_q[r]));
      end
    end
  end

  assign world_o.valid      = valid_q[NumStages-1];
  assign world_o.world_lo_x = wlo_q[0];
  assign world_o.world_lo_y = wlo_q[1];
  assign world_o.world_lo_z = wlo_q[2];
  assign world_o.world_hi_x = whi_q[0];
  assign world_o.world_hi_y = whi_q[1];
  assign world_o.world_hi_z = whi_q[2];

`ifndef SYNTH
  // per-term ordering and monotonic saturation keep the box well formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    world_o.valid |-> (world_o.world_lo_x <= world_o.world_hi_x) &&
                      (world_o.world_lo_y <= world_o.world_hi_y) &&
                      (world_o.world_lo_z <= world_o.world_hi_z))
    else $error("world box min exceeds max");

  // an empty first stage always takes a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> box_i.ready)
    else $error("input stalled with empty first stage");

  // a blocked stage keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[1] && !rdy[2]) |=> valid_q[1])
    else $error("blocked product stage dropped its item");

  // a taken result with nothing behind it leaves the output empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (world_o.valid && world_o.ready && !valid_q[NumStages-2]) |=> !world_o.valid)
    else $error("output beat repeated");
`endif

endmodule

// ----- test/aat_checker.sv -----
// checker for the box transform: tracks the matrix, predicts each world box, compares
`timescale 1ns / 1ps
module aat_checker
  import aat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 box_valid_i,
  input  logic                 box_ready_i,
  input  logic [5:0][31:0]     box_i,
  input  logic                 world_valid_i,
  input  logic                 world_ready_i,
  input  logic [5:0][31:0]     world_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [CfgAddrW-1:0]  paddr_i,
  input  logic [CfgDataW-1:0]  pwdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef logic [5:0][31:0] corners_t;

  logic [CfgDataW-1:0] matrix_q [NumRegs];
  corners_t            world_box_q [$];
  string               field_name [6] = '{"lo_x", "lo_y", "lo_z", "hi_x", "hi_y", "hi_z"};

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // shadow of the matrix registers, written on the apb access beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) matrix_q[i] <= RegReset[i];
    end else if (psel_i && penable_i && pwrite_i && pready_i) begin
      if (paddr_i[CfgAddrW-1:3] < NumRegs) begin
        matrix_q[paddr_i[CfgAddrW-1:3]] <= pwdata_i;
      end
    end
  end

  function automatic logic signed [63:0] mat_entry(int row, int col);
    logic [CfgDataW-1:0] r;
    logic signed [63:0]  v;
    r = matrix_q[row * 2 + col / 2];
    if (col % 2 == 1) begin
      v = q16_t'(r[63:32]);
    end else begin
      v = q16_t'(r[31:0]);
    end
    return v;
  endfunction

  function automatic logic [31:0] clamp_q16(logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // per-term min/max gives the same box as trying all eight corners
  function automatic corners_t transform_box(corners_t b);
    corners_t           r;
    logic signed [63:0] lo, hi, m, a, c, p, q;
    for (int row = 0; row < 3; row++) begin
      lo = mat_entry(row, 3);
      hi = lo;
      for (int col = 0; col < 3; col++) begin
        m = mat_entry(row, col);
        a = q16_t'(b[col]);
        c = q16_t'(b[col + 3]);
        p = (m * a) >>> 16;
        q = (m * c) >>> 16;
        if (p < q) begin
          lo = lo + p;
          hi = hi + q;
        end else begin
          lo = lo + q;
          hi = hi + p;
        end
      end
      r[row]     = clamp_q16(lo);
      r[row + 3] = clamp_q16(hi);
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    corners_t want;
    if (rst_ni) begin
      if (world_valid_i && world_ready_i) begin
        if (world_box_q.size() == 0) begin
          $display("%0t: world beat with no box pending, actual %h", $realtime, world_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = world_box_q.pop_front();
          for (int f = 0; f < 6; f++) begin
            if (world_i[f] !== want[f]) begin
              $display("%0t: world_%s expected %h actual %h",
                       $realtime, field_name[f], want[f], world_i[f]);
              fail_count_o = fail_count_o + 1;
            end
          end
        end
      end
      if (box_valid_i && box_ready_i) begin
        world_box_q = {world_box_q, transform_box(box_i)};
      end
    end
    pending_o = world_box_q.size();
  end

endmodule

// ----- test/tb.sv -----
// testbench top for the box transform: clock, reset, apb setup, box stimulus, verdict
`timescale 1ns / 1ps
module tb;
  import aat_pkg::*;

  typedef logic [5:0][31:0] corners_t;

  localparam logic [RegIdxW-1:0] RegUnusedLo = 3'd6;
  localparam logic [RegIdxW-1:0] RegUnusedHi = 3'd7;

  localparam logic [31:0] QMax  = 32'h7fff_ffff;
  localparam logic [31:0] QMin  = 32'h8000_0000;
  localparam logic [31:0] QOne  = 32'h0001_0000;
  localparam logic [31:0] QZero = 32'h0000_0000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                idle_en;
  int                  fail_count;
  int                  pending;

  aat_box_if   box_ch ();
  aat_world_if world_ch ();

  aabb_affine_transform i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .box_i   (box_ch),
    .world_o (world_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  aat_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .box_valid_i   (box_ch.valid),
    .box_ready_i   (box_ch.ready),
    .box_i         ({box_ch.box_hi_z, box_ch.box_hi_y, box_ch.box_hi_x,
                     box_ch.box_lo_z, box_ch.box_lo_y, box_ch.box_lo_x}),
    .world_valid_i (world_ch.valid),
    .world_ready_i (world_ch.ready),
    .world_i       ({world_ch.world_hi_z, world_ch.world_hi_y, world_ch.world_hi_x,
                     world_ch.world_lo_z, world_ch.world_lo_y, world_ch.world_lo_x}),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stall bursts while idling is on
  initial begin
    int stall_left;
    stall_left = 0;
    world_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        world_ch.ready = 1'b0;
        stall_left = stall_left - 1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        world_ch.ready = 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        world_ch.ready = 1'b1;
      end
    end
  end

  function automatic corners_t mk_box(logic [31:0] lx, ly, lz, hx, hy, hz);
    return {hz, hy, hx, lz, ly, lx};
  endfunction

  function automatic logic [31:0] pick_extreme();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = QMax;
      1: v = QMin;
      2: v = QZero;
      3: v = 32'h0000_0001;
      default: v = 32'hffff_ffff;
    endcase
    return v;
  endfunction

  // mostly moderate values so that saturation stays the exception
  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = $urandom;
      1: v = pick_extreme();
      default: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_entry();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: v = pick_extreme();
      default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rand_reg();
    return {rand_coord(), rand_entry()};
  endfunction

  function automatic corners_t rand_box();
    corners_t    b;
    logic [31:0] t;
    bit          ordered;
    ordered = ($urandom_range(0, 7) != 0);
    for (int c = 0; c < 3; c++) begin
      b[c]     = rand_coord();
      b[c + 3] = rand_coord();
      if (ordered && ($signed(b[c]) > $signed(b[c + 3]))) begin
        t        = b[c];
        b[c]     = b[c + 3];
        b[c + 3] = t;
      end
    end
    return b;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_box(input corners_t b);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      box_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    box_ch.valid    = 1'b1;
    box_ch.box_lo_x = b[0];
    box_ch.box_lo_y = b[1];
    box_ch.box_lo_z = b[2];
    box_ch.box_hi_x = b[3];
    box_ch.box_hi_y = b[4];
    box_ch.box_hi_z = b[5];
    do @(posedge clk); while (!box_ch.ready);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CfgAddrW'({idx, 3'b000});
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // registers change only with the pipeline empty
  task automatic wait_drained();
    box_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_matrix(input logic [63:0] r0a, r0b, r1a, r1b, r2a, r2b);
    wait_drained();
    apb_write(RegRow0Cols01, r0a);
    apb_write(RegRow0Cols23, r0b);
    apb_write(RegRow1Cols01, r1a);
    apb_write(RegRow1Cols23, r1b);
    apb_write(RegRow2Cols01, r2a);
    apb_write(RegRow2Cols23, r2b);
  endtask

  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_en         = 1'b1;
    box_ch.valid    = 1'b0;
    box_ch.box_lo_x = '0;
    box_ch.box_lo_y = '0;
    box_ch.box_lo_z = '0;
    box_ch.box_hi_x = '0;
    box_ch.box_hi_y = '0;
    box_ch.box_hi_z = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // matrix as it comes out of reset
    send_box(mk_box(QZero, QZero, QZero, QZero, QZero, QZero));
    send_box(mk_box(QMax, QMax, QMax, QMax, QMax, QMax));
    send_box(mk_box(QMin, QMin, QMin, QMin, QMin, QMin));
    send_box(mk_box(QMin, QMin, QMin, QMax, QMax, QMax));
    // corners out of order on every axis
    send_box(mk_box(QMax, QMax, QMax, QMin, QMin, QMin));
    // one raw step either side of zero exercises the floor cut
    send_box(mk_box(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                    32'h0000_0001, 32'h0000_0001, 32'h0000_0001));

    // identity with translation
    set_matrix({QZero, QOne}, {32'h0005_0000, QZero},
               {QOne, QZero}, {32'hfffd_0000, QZero},
               {QZero, QZero}, {32'h7fff_0000, QOne});
    send_box(mk_box(QZero, QZero, QZero, QOne, QOne, QOne));
    send_box(mk_box(QOne, 32'hffff_0000, QZero, QZero, QOne, 32'h0002_8000));
    send_box(mk_box(QMin, QMin, QMin, QMax, QMax, QMax));
    send_box(mk_box(32'h0003_0000, QZero, QZero, 32'hfffd_0000, QZero, QZero));

    // largest entries: saturation on both the high and the low side
    set_matrix({QMax, QMax}, {QMax, QMax}, {QMax, QMax}, {QMax, QMax},
               {QMax, QMax}, {QMax, QMax});
    send_box(mk_box(QMax, QMax, QMax, QMax, QMax, QMax));
    send_box(mk_box(QMin, QMin, QMin, QMin, QMin, QMin));
    send_box(mk_box(QMin, QZero, QMax, QMax, QZero, QMin));

    // most negative entries: product of two minima is the widest case
    set_matrix({QMin, QMin}, {QMin, QMin}, {QMin, QMin}, {QMin, QMin},
               {QMin, QMin}, {QMin, QMin});
    send_box(mk_box(QMin, QMin, QMin, QMin, QMin, QMin));
    send_box(mk_box(QMax, QMax, QMax, QMax, QMax, QMax));
    send_box(mk_box(QZero, QZero, QZero, QZero, QZero, QZero));

    // writes past the last register leave the matrix alone
    wait_drained();
    apb_write(RegUnusedLo, {$urandom, $urandom});
    apb_write(RegUnusedHi, {$urandom, $urandom});
    send_box(mk_box(QOne, QOne, QOne, QOne, QOne, QOne));
    send_box(mk_box(QMin, QMin, QMin, QMax, QMax, QMax));

    set_matrix('0, '0, '0, '0, '0, '0);
    send_box(mk_box(QMin, QMin, QMin, QMax, QMax, QMax));

    set_matrix('1, '1, '1, '1, '1, '1);
    send_box(mk_box(QMin, QMin, QMin, QMax, QMax, QMax));

    // random matrices, each with a run of random boxes
    for (int phase = 0; phase < 7; phase++) begin
      set_matrix(rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg(), rand_reg());
      for (int grp = 0; grp < 3; grp++) begin
        idle_en = (phase != 6) && ($urandom_range(0, 3) != 0);
        for (int n = 0; n < 50; n++) send_box(rand_box());
      end
    end

    idle_en = 1'b0;
    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
